@@ design/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg
// shared widths, command codes and constants of the line sensor position core
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

	localparam int SAMPLE_FIELDS = 5;
	localparam int SAMPLE_W      = 12;
	localparam int HALF_W        = 11;
	localparam int MIN_W         = 12;
	localparam int DEN_W         = 8;
	localparam int SCALED_W      = 15;
	localparam int POS_W         = 10;
	localparam int MAP_W         = 8;
	localparam int CMD_W         = 2;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_W         = 11;
	localparam int LINE_THR_W    = 8;
	localparam int S_TDATA_W     = 64;
	localparam int M_TDATA_W     = 24;

	// shared divider: quotient bits and counter width
	localparam int QUO_W    = 15;
	localparam int QBITS_W  = 4;
	localparam logic [QBITS_W-1:0] SCALED_Q = QBITS_W'(SCALED_W);
	localparam logic [QBITS_W-1:0] POS_Q    = QBITS_W'(POS_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_RESTART = 2'd0,
		CMD_CAL     = 2'd1,
		CMD_DENOM   = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THR  = 1'b1;

	localparam logic [MIN_W-1:0]      CAL_MIN_RST  = 12'd4095;
	localparam logic [LINE_THR_W-1:0] LINE_THR_RST = 8'd5;

	localparam int SCALE_MUL = 10;
	localparam int POS_STEP  = 100;

	// x / 10 as (x * 52429) >> 19, exact over the 11-bit span
	localparam int DIV_PROD_W  = 27;
	localparam int DIV10_MUL   = 52429;
	localparam int DIV10_SHIFT = 19;

	localparam logic [POS_W-1:0] POS_LEFT   = 10'd100;
	localparam logic [POS_W-1:0] POS_CENTER = 10'd300;
	localparam logic [POS_W-1:0] LOST_LOW   = 10'd200;
	localparam logic [POS_W-1:0] LOST_HIGH  = 10'd400;

endpackage

`default_nettype wire

@@ design/lsp_div.sv @@
// ----------------------------------------------------------------------------
// lsp_div
// restoring divider, one quotient bit per cycle, quotient bit count per op
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_div
	import lsp_pkg::*;
#(
	parameter int DVD_W = 27,
	parameter int DVS_W = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [DVS_W-1:0]   divisor,
	input  logic [QBITS_W-1:0] qbits,
	output logic               done,
	output logic [QUO_W-1:0]   quotient
);

	localparam int SH_W  = DVS_W + QUO_W - 1;
	localparam int CMP_W = (DVD_W > SH_W) ? DVD_W : SH_W;

	logic [DVD_W-1:0]   rem_q;
	logic [SH_W-1:0]    dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QBITS_W-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [CMP_W-1:0] rem_x;
	logic [CMP_W-1:0] dsh_x;
	logic [CMP_W-1:0] rem_sub;
	logic             fits;
	logic [SH_W-1:0]  dsh_load;

	assign rem_x    = CMP_W'(rem_q);
	assign dsh_x    = CMP_W'(dsh_q);
	assign fits     = rem_x >= dsh_x;
	assign rem_sub  = rem_x - dsh_x;
	assign dsh_load = SH_W'(divisor) << (qbits - QBITS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= qbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - QBITS_W'(1);
				if (cnt_q == QBITS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= dsh_load;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVD_W'(rem_sub);
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ design/line_sensor_position_core.sv @@
// ----------------------------------------------------------------------------
// line_sensor_position_core
// calibrated weighted-average line position from a row of reflectance sensors
// ----------------------------------------------------------------------------
// channel  direction  signals                       beat contents
// s_*      in         s_tvalid s_tready s_tdata     tdata: sample_0..sample_4
//                     s_tuser                       tuser: command
// m_*      out        m_tvalid m_tready m_tdata     tdata: position, hit map
//                     m_tuser                       tuser: line_lost
// cfg_*    in         cfg_valid cfg_ready           index 0 noise, 1 line thr
//                     cfg_index cfg_data
//
// restart resets calibration without leaving idle; calibration sample and denominators step through the sensors in turn
// a read steps through the sensors: each non-quiet sensor's scaling and
// the final average of a non-empty map share one restoring divider, one quotient bit a cycle
// s_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next beat is taken
// meanwhile, and the sequencer stalls only when a second result is ready
// reset restores calibration, denominators and thresholds at once
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_position_core
	import lsp_pkg::*;
#(
	parameter int SENSOR_COUNT = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_0 .. sample_4, 12 bits each
	input  logic [CMD_W-1:0]      s_tuser,   // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // position, hit map
	output logic [0:0]            m_tuser,   // line_lost
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int IDX_W      = $clog2(SENSOR_COUNT);
	localparam int SCALED_MAX = ((1 << HALF_W) - 1) * SCALE_MUL;
	localparam int TOTAL_W    = $clog2(SENSOR_COUNT * SCALED_MAX + 1);
	localparam int WT_W       = $clog2(SENSOR_COUNT * POS_STEP + 1);
	localparam int WEIGHT_W   =
		$clog2(SCALED_MAX * POS_STEP * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2 + 1);
	localparam logic [POS_W-1:0] POS_RIGHT = POS_W'(SENSOR_COUNT * POS_STEP);
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SENSOR_COUNT - 1);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_CAL       = 9'b000000010,
		ST_DEN       = 9'b000000100,
		ST_RD_PREP   = 9'b000001000,
		ST_RD_WAIT   = 9'b000010000,
		ST_RD_ACC    = 9'b000100000,
		ST_FIN_START = 9'b001000000,
		ST_FIN_WAIT  = 9'b010000000,
		ST_PUT       = 9'b100000000
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [HALF_W-1:0]     samp_q [SENSOR_COUNT];
	logic [MIN_W-1:0]      min_q  [SENSOR_COUNT];
	logic [HALF_W-1:0]     max_q  [SENSOR_COUNT];
	logic [DEN_W-1:0]      den_q  [SENSOR_COUNT];
	logic [CFG_W-1:0]      noise_q;
	logic [LINE_THR_W-1:0] line_q;
	logic [POS_W-1:0]      prev_pos_q;
	logic                  lost_q;
	logic [WEIGHT_W-1:0]   weighted_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [SENSOR_COUNT-1:0] map_q;
	logic [SCALED_W-1:0]   scaled_q;
	logic                  m_tvalid_q;
	logic [POS_W-1:0]      out_pos_q;
	logic [MAP_W-1:0]      out_map_q;
	logic                  out_lost_q;

	logic [HALF_W-1:0]     samp_in [SENSOR_COUNT];
	logic                  in_beat;
	cmd_t                  cmd;

	for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_samp
		if (i < SAMPLE_FIELDS) begin : g_live
			assign samp_in[i] = s_tdata[i*SAMPLE_W+1 +: HALF_W];
		end else begin : g_pad
			assign samp_in[i] = '0;
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign cmd       = cmd_t'(s_tuser);
	assign cfg_ready = 1'b1;

	// current sensor
	logic [HALF_W-1:0]     v;
	logic [MIN_W-1:0]      mn;
	logic [HALF_W-1:0]     mx;
	logic [DEN_W-1:0]      dn;
	logic [MIN_W-1:0]      vlo;
	logic [MIN_W-1:0]      vc;
	logic [HALF_W-1:0]     diff;
	logic [SCALED_W-1:0]   dvd10;
	logic                  quiet;
	logic                  span_ok;
	logic [HALF_W-1:0]     span;
	logic [DIV_PROD_W-1:0] span_prod;
	logic [DEN_W-1:0]      den_new;
	logic [WT_W-1:0]       wt;
	logic [POS_W-1:0]      snap_pos;
	logic                  out_load;

	assign v  = samp_q[idx_q];
	assign mn = min_q[idx_q];
	assign mx = max_q[idx_q];
	assign dn = den_q[idx_q];

	assign vlo   = (MIN_W'(v) < mn) ? mn : MIN_W'(v);
	assign vc    = (vlo > MIN_W'(mx)) ? MIN_W'(mx) : vlo;
	assign diff  = (vc >= mn) ? HALF_W'(vc - mn) : '0;
	assign dvd10 = SCALED_W'(diff) * SCALED_W'(SCALE_MUL);
	assign quiet = (dn == '0) || (vc < MIN_W'(noise_q));

	assign span_ok   = MIN_W'(mx) >= mn;
	assign span      = HALF_W'(MIN_W'(mx) - mn);
	assign span_prod = DIV_PROD_W'(span) * DIV_PROD_W'(DIV10_MUL);
	assign den_new   = span_prod[DIV10_SHIFT +: DEN_W];

	assign wt = (WT_W'(idx_q) + WT_W'(1)) * WT_W'(POS_STEP);

	always_comb begin
		if (prev_pos_q < LOST_LOW) begin
			snap_pos = POS_LEFT;
		end else if (prev_pos_q > LOST_HIGH) begin
			snap_pos = POS_RIGHT;
		end else begin
			snap_pos = POS_CENTER;
		end
	end

	// shared divider
	logic                  div_start;
	logic [WEIGHT_W-1:0]   div_dvd;
	logic [TOTAL_W-1:0]    div_dvs;
	logic [QBITS_W-1:0]    div_qbits;
	logic                  div_done;
	logic [QUO_W-1:0]      div_quo;

	always_comb begin
		if (state_q == ST_FIN_START) begin
			div_start = (map_q != '0);
			div_dvd   = weighted_q;
			div_dvs   = total_q;
			div_qbits = POS_Q;
		end else begin
			div_start = (state_q == ST_RD_PREP) && !quiet;
			div_dvd   = WEIGHT_W'(dvd10);
			div_dvs   = TOTAL_W'(dn);
			div_qbits = SCALED_Q;
		end
	end

	lsp_div #(
		.DVD_W (WEIGHT_W),
		.DVS_W (TOTAL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.qbits    (div_qbits),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_load = (state_q == ST_PUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			noise_q    <= '0;
			line_q     <= LINE_THR_RST;
			prev_pos_q <= '0;
			lost_q     <= 1'b0;
			weighted_q <= '0;
			total_q    <= '0;
			map_q      <= '0;
			scaled_q   <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				min_q[i] <= CAL_MIN_RST;
				max_q[i] <= '0;
				den_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_NOISE_THR: noise_q <= cfg_data;
					REG_LINE_THR:  line_q  <= cfg_data[LINE_THR_W-1:0];
					default: ;
				endcase
			end

			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_beat) begin
						case (cmd)
							CMD_RESTART: begin
								for (int i = 0; i < SENSOR_COUNT; i++) begin
									min_q[i] <= CAL_MIN_RST;
									max_q[i] <= '0;
								end
							end
							CMD_CAL:   state_q <= ST_CAL;
							CMD_DENOM: state_q <= ST_DEN;
							CMD_READ: begin
								weighted_q <= '0;
								total_q    <= '0;
								map_q      <= '0;
								state_q    <= ST_RD_PREP;
							end
							default: ;
						endcase
					end
				end
				ST_CAL: begin
					if (MIN_W'(v) < mn) begin
						min_q[idx_q] <= MIN_W'(v);
					end
					if (v > mx) begin
						max_q[idx_q] <= v;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DEN: begin
					den_q[idx_q] <= span_ok ? den_new : '0;
					if (idx_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_RD_PREP: begin
					if (quiet) begin
						scaled_q <= '0;
						state_q  <= ST_RD_ACC;
					end else begin
						state_q <= ST_RD_WAIT;
					end
				end
				ST_RD_WAIT: begin
					if (div_done) begin
						scaled_q <= div_quo[SCALED_W-1:0];
						state_q  <= ST_RD_ACC;
					end
				end
				ST_RD_ACC: begin
					weighted_q <= weighted_q + WEIGHT_W'(scaled_q) * WEIGHT_W'(wt);
					total_q    <= total_q + TOTAL_W'(scaled_q);
					if (scaled_q > SCALED_W'(line_q)) begin
						map_q[idx_q] <= 1'b1;
					end
					if (idx_q == IDX_LAST) begin
						state_q <= ST_FIN_START;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_RD_PREP;
					end
				end
				ST_FIN_START: begin
					if (map_q == '0) begin
						prev_pos_q <= snap_pos;
						lost_q     <= 1'b1;
						state_q    <= ST_PUT;
					end else begin
						lost_q  <= 1'b0;
						state_q <= ST_FIN_WAIT;
					end
				end
				ST_FIN_WAIT: begin
					if (div_done) begin
						prev_pos_q <= div_quo[POS_W-1:0];
						state_q    <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				samp_q[i] <= samp_in[i];
			end
		end
		if (out_load) begin
			out_pos_q  <= prev_pos_q;
			out_map_q  <= MAP_W'(map_q);
			out_lost_q <= lost_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({out_map_q, out_pos_q});
	assign m_tuser  = out_lost_q;

	// lost line snaps to one of three positions
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[POS_W-1:0] == POS_LEFT ||
			m_tdata[POS_W-1:0] == POS_CENTER || m_tdata[POS_W-1:0] == POS_RIGHT)
		else $error("lost position off the snap points");

	// a tracked line has at least one sensor in the map
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[POS_W +: MAP_W] != '0)
		else $error("line seen with empty map");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[POS_W-1:0] <= POS_RIGHT)
		else $error("position beyond rightmost sensor");

	// divider results land only where the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_RD_WAIT || state_q == ST_FIN_WAIT)
		else $error("divider done outside a wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_done)
		else $error("divider done right after start");

endmodule

`default_nettype wire
